>>> design/ssc_pkg.sv
// ----------------------------------------------------------------------------
// ssc_pkg
// Shared widths, coefficient bundle and controller command codes for the
// stereo state-variable-filter soft-clip distortion block.
// ----------------------------------------------------------------------------
package ssc_pkg;

  localparam int SAMPLE_BITS    = 24;
  localparam int COEF_FRAC_BITS = 16;
  localparam int STATE_BITS     = SAMPLE_BITS + 8;
  localparam int FRAC_BITS      = SAMPLE_BITS - 1;
  localparam int COEF_W         = 24;   // signed Q8.16 coefficients
  localparam int DRIVE_W        = 23;
  localparam int GAIN_W         = 17;
  localparam int NUM_REGS       = 8;
  localparam int CFG_IDX_W      = $clog2(NUM_REGS);

  // clipper operand: +/-1.0 in Q1.F plus a sign
  localparam int CLIP_W  = SAMPLE_BITS + 1;
  // multiplier operands and product
  localparam int MUL_A_W = STATE_BITS + 1;
  localparam int MUL_B_W = (CLIP_W > COEF_W + 1) ? CLIP_W : COEF_W + 1;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  // difference*highpass plus two clipped terms
  localparam int SUM_W   = STATE_BITS + COEF_W - COEF_FRAC_BITS + 1;

  localparam logic [CFG_IDX_W-1:0] REG_FEEDBACK = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_TUNE     = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_UPDATE   = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_HIGHPASS = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_DRIVE    = CFG_IDX_W'(4);
  localparam logic [CFG_IDX_W-1:0] REG_TRIM     = CFG_IDX_W'(5);
  localparam logic [CFG_IDX_W-1:0] REG_DRY      = CFG_IDX_W'(6);
  localparam logic [CFG_IDX_W-1:0] REG_WET      = CFG_IDX_W'(7);

  typedef struct packed {
    logic signed [COEF_W-1:0] feedback;
    logic signed [COEF_W-1:0] tune;
    logic signed [COEF_W-1:0] update;
    logic signed [COEF_W-1:0] highpass;
    logic [DRIVE_W-1:0]       drive;
    logic [GAIN_W-1:0]        trim;
    logic [GAIN_W-1:0]        dry;
    logic [GAIN_W-1:0]        wet;
  } coef_t;

  // operand pair fed to the lane multiplier
  typedef enum logic [3:0] {
    MUL_NONE,
    MUL_LOW_TUNE,
    MUL_BAND_FB,
    MUL_DIFF_UPD,
    MUL_DIFF_HP,
    MUL_BAND_DRV,
    MUL_LOW_DRV,
    MUL_XB_XB,
    MUL_X2B_XB,
    MUL_XL_XL,
    MUL_X2L_XL,
    MUL_IN_DRY,
    MUL_SUM_TRIM,
    MUL_WET_WG
  } mul_op_t;

  // register that takes the previous product
  typedef enum logic [3:0] {
    WB_NONE,
    WB_BAND,
    WB_DIFF,
    WB_LOW,
    WB_SUM_HP,
    WB_XB,
    WB_X2B,
    WB_CB,
    WB_XL,
    WB_X2L,
    WB_CL,
    WB_ACC,
    WB_WET,
    WB_MIX
  } wb_op_t;

  typedef struct packed {
    logic    in_load;
    logic    out_load;
    mul_op_t mul_op;
    wb_op_t  wb_op;
  } ssc_cmd_t;

endpackage

>>> design/ssc_lane.sv
// ----------------------------------------------------------------------------
// ssc_lane
// One channel datapath: filter state, one shared multiplier with a product
// register, rounding and saturation on writeback.
// ----------------------------------------------------------------------------
module ssc_lane (
  input  logic                                clk,
  input  logic                                rst,
  input  ssc_pkg::ssc_cmd_t                   cmd,
  input  ssc_pkg::coef_t                      coef,
  input  logic signed [ssc_pkg::SAMPLE_BITS-1:0] sample_in,
  output logic signed [ssc_pkg::SAMPLE_BITS-1:0] sample_out
);
  import ssc_pkg::*;

  localparam int EXT_W = PROD_W + 1;
  localparam int WET_W = STATE_BITS + 1;
  localparam logic signed [PROD_W-1:0] HALF_C = PROD_W'(1) <<< (COEF_FRAC_BITS - 1);
  localparam logic signed [PROD_W-1:0] HALF_F = PROD_W'(1) <<< (FRAC_BITS - 1);
  localparam logic signed [EXT_W-1:0]  HALF_M = EXT_W'(1) <<< (COEF_FRAC_BITS - 1);

  function automatic logic signed [STATE_BITS-1:0] sat_st(input logic signed [EXT_W-1:0] v);
    logic signed [EXT_W-1:0] hi;
    logic signed [EXT_W-1:0] lo;
    hi = (EXT_W'(1) <<< (STATE_BITS - 1)) - EXT_W'(1);
    lo = -hi - EXT_W'(1);
    if (v > hi) return hi[STATE_BITS-1:0];
    else if (v < lo) return lo[STATE_BITS-1:0];
    else return v[STATE_BITS-1:0];
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] sat_smp(input logic signed [EXT_W-1:0] v);
    logic signed [EXT_W-1:0] hi;
    logic signed [EXT_W-1:0] lo;
    hi = (EXT_W'(1) <<< (SAMPLE_BITS - 1)) - EXT_W'(1);
    lo = -hi - EXT_W'(1);
    if (v > hi) return hi[SAMPLE_BITS-1:0];
    else if (v < lo) return lo[SAMPLE_BITS-1:0];
    else return v[SAMPLE_BITS-1:0];
  endfunction

  // hard limit of the clipper input to +/-1.0
  function automatic logic signed [CLIP_W-1:0] clamp_x(input logic signed [PROD_W-1:0] v);
    logic signed [PROD_W-1:0] one;
    one = PROD_W'(1) <<< FRAC_BITS;
    if (v > one) return one[CLIP_W-1:0];
    else if (v < -one) return -one[CLIP_W-1:0];
    else return v[CLIP_W-1:0];
  endfunction

  // (3x - x^3) / 2, rounded; at x = +/-1 this returns x itself
  function automatic logic signed [CLIP_W-1:0] cubic(input logic signed [CLIP_W-1:0] x,
                                                     input logic signed [CLIP_W-1:0] x3);
    logic signed [CLIP_W+3:0] t;
    t = (CLIP_W+4)'(x) * (CLIP_W+4)'(3) - (CLIP_W+4)'(x3) + (CLIP_W+4)'(1);
    t = t >>> 1;
    return t[CLIP_W-1:0];
  endfunction

  logic signed [SAMPLE_BITS-1:0] in_smp;
  logic signed [STATE_BITS-1:0]  band;
  logic signed [STATE_BITS-1:0]  low;
  logic signed [STATE_BITS-1:0]  diff;
  logic signed [SUM_W-1:0]       sum;
  logic signed [CLIP_W-1:0]      xb;
  logic signed [CLIP_W-1:0]      xl;
  logic signed [CLIP_W-1:0]      x2b;
  logic signed [CLIP_W-1:0]      x2l;
  logic signed [PROD_W-1:0]      acc;
  logic signed [WET_W-1:0]       wet;
  logic signed [SAMPLE_BITS-1:0] mix;
  logic signed [PROD_W-1:0]      prod;

  logic signed [MUL_A_W-1:0] op_a;
  logic signed [MUL_B_W-1:0] op_b;
  logic signed [PROD_W-1:0]  r_coef;
  logic signed [PROD_W-1:0]  r_frac;
  logic signed [CLIP_W-1:0]  x3;
  logic signed [EXT_W-1:0]   mix_sum;

  always_comb begin
    op_a = '0;
    op_b = '0;
    unique case (cmd.mul_op)
      MUL_LOW_TUNE: begin
        op_a = MUL_A_W'(low);
        op_b = MUL_B_W'(coef.tune);
      end
      MUL_BAND_FB: begin
        op_a = MUL_A_W'(band);
        op_b = MUL_B_W'(coef.feedback);
      end
      MUL_DIFF_UPD: begin
        op_a = MUL_A_W'(diff);
        op_b = MUL_B_W'(coef.update);
      end
      MUL_DIFF_HP: begin
        op_a = MUL_A_W'(diff);
        op_b = MUL_B_W'(coef.highpass);
      end
      MUL_BAND_DRV: begin
        op_a = MUL_A_W'(band);
        op_b = MUL_B_W'(signed'({1'b0, coef.drive}));
      end
      MUL_LOW_DRV: begin
        op_a = MUL_A_W'(low);
        op_b = MUL_B_W'(signed'({1'b0, coef.drive}));
      end
      MUL_XB_XB: begin
        op_a = MUL_A_W'(xb);
        op_b = MUL_B_W'(xb);
      end
      MUL_X2B_XB: begin
        op_a = MUL_A_W'(x2b);
        op_b = MUL_B_W'(xb);
      end
      MUL_XL_XL: begin
        op_a = MUL_A_W'(xl);
        op_b = MUL_B_W'(xl);
      end
      MUL_X2L_XL: begin
        op_a = MUL_A_W'(x2l);
        op_b = MUL_B_W'(xl);
      end
      MUL_IN_DRY: begin
        op_a = MUL_A_W'(in_smp);
        op_b = MUL_B_W'(signed'({1'b0, coef.dry}));
      end
      MUL_SUM_TRIM: begin
        op_a = MUL_A_W'(signed'(sum[STATE_BITS-1:0]));
        op_b = MUL_B_W'(signed'({1'b0, coef.trim}));
      end
      MUL_WET_WG: begin
        op_a = MUL_A_W'(wet);
        op_b = MUL_B_W'(signed'({1'b0, coef.wet}));
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  // round half up at the coefficient and the sample binary point
  assign r_coef  = (prod + HALF_C) >>> COEF_FRAC_BITS;
  assign r_frac  = (prod + HALF_F) >>> FRAC_BITS;
  assign x3      = CLIP_W'(r_frac);
  assign mix_sum = (EXT_W'(acc) + EXT_W'(prod) + HALF_M) >>> COEF_FRAC_BITS;

  always_ff @(posedge clk) begin
    prod <= op_a * op_b;
    if (cmd.in_load) begin
      in_smp <= sample_in;
    end
    unique case (cmd.wb_op)
      WB_DIFF:   diff <= sat_st(EXT_W'(r_coef) + EXT_W'(low) - EXT_W'(in_smp));
      WB_SUM_HP: sum  <= SUM_W'(r_coef);
      WB_XB:     xb   <= clamp_x(r_coef);
      WB_X2B:    x2b  <= CLIP_W'(r_frac);
      WB_CB:     sum  <= sum + SUM_W'(cubic(xb, x3));
      WB_XL:     xl   <= clamp_x(r_coef);
      WB_X2L:    x2l  <= CLIP_W'(r_frac);
      WB_CL:     sum  <= SUM_W'(sat_st(EXT_W'(sum) + EXT_W'(cubic(xl, x3))));
      WB_ACC:    acc  <= prod;
      WB_WET:    wet  <= WET_W'(r_coef);
      WB_MIX:    mix  <= sat_smp(mix_sum);
      default: ;
    endcase
  end

  // integrator state
  always_ff @(posedge clk) begin
    if (rst) begin
      band <= '0;
      low  <= '0;
    end else begin
      if (cmd.wb_op == WB_BAND) begin
        band <= sat_st(EXT_W'(band) + EXT_W'(r_coef));
      end
      if (cmd.wb_op == WB_LOW) begin
        low <= sat_st(EXT_W'(low) + EXT_W'(r_coef));
      end
    end
  end

  assign sample_out = mix;

endmodule

>>> design/ssc_ctrl.sv
// ----------------------------------------------------------------------------
// ssc_ctrl
// Sequencer: takes an item, steps both lanes through the multiply and
// writeback schedule, then hands the result to the output register.
// ----------------------------------------------------------------------------
module ssc_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              out_free,
  output ssc_pkg::ssc_cmd_t cmd
);
  import ssc_pkg::*;

  localparam int          STEP_W    = 5;
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(17);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_HOLD = 3'b100
  } state_t;

  state_t            state;
  state_t            state_next;
  logic [STEP_W-1:0] step;
  logic [STEP_W-1:0] step_next;
  mul_op_t           mul_op;
  wb_op_t            wb_op;

  // a product issued in one step is written back in the next one
  always_comb begin
    mul_op = MUL_NONE;
    wb_op  = WB_NONE;
    unique case (step)
      STEP_W'(0):  begin mul_op = MUL_LOW_TUNE; wb_op = WB_NONE;   end
      STEP_W'(1):  begin mul_op = MUL_IN_DRY;   wb_op = WB_BAND;   end
      STEP_W'(2):  begin mul_op = MUL_BAND_FB;  wb_op = WB_ACC;    end
      STEP_W'(3):  begin mul_op = MUL_BAND_DRV; wb_op = WB_DIFF;   end
      STEP_W'(4):  begin mul_op = MUL_DIFF_UPD; wb_op = WB_XB;     end
      STEP_W'(5):  begin mul_op = MUL_XB_XB;    wb_op = WB_LOW;    end
      STEP_W'(6):  begin mul_op = MUL_DIFF_HP;  wb_op = WB_X2B;    end
      STEP_W'(7):  begin mul_op = MUL_X2B_XB;   wb_op = WB_SUM_HP; end
      STEP_W'(8):  begin mul_op = MUL_LOW_DRV;  wb_op = WB_CB;     end
      STEP_W'(9):  begin mul_op = MUL_NONE;     wb_op = WB_XL;     end
      STEP_W'(10): begin mul_op = MUL_XL_XL;    wb_op = WB_NONE;   end
      STEP_W'(11): begin mul_op = MUL_NONE;     wb_op = WB_X2L;    end
      STEP_W'(12): begin mul_op = MUL_X2L_XL;   wb_op = WB_NONE;   end
      STEP_W'(13): begin mul_op = MUL_NONE;     wb_op = WB_CL;     end
      STEP_W'(14): begin mul_op = MUL_SUM_TRIM; wb_op = WB_NONE;   end
      STEP_W'(15): begin mul_op = MUL_NONE;     wb_op = WB_WET;    end
      STEP_W'(16): begin mul_op = MUL_WET_WG;   wb_op = WB_NONE;   end
      STEP_W'(17): begin mul_op = MUL_NONE;     wb_op = WB_MIX;    end
      default:     begin mul_op = MUL_NONE;     wb_op = WB_NONE;   end
    endcase
  end

  always_comb begin
    state_next   = state;
    step_next    = step;
    in_ready     = 1'b0;
    cmd.in_load  = 1'b0;
    cmd.out_load = 1'b0;
    cmd.mul_op   = MUL_NONE;
    cmd.wb_op    = WB_NONE;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.in_load = 1'b1;
          step_next   = '0;
          state_next  = ST_RUN;
        end
      end
      ST_RUN: begin
        cmd.mul_op = mul_op;
        cmd.wb_op  = wb_op;
        step_next  = step + STEP_W'(1);
        if (step == LAST_STEP) begin
          state_next = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

endmodule

>>> design/stereo_svf_soft_clip_distortion.sv
// ----------------------------------------------------------------------------
// stereo_svf_soft_clip_distortion
// Stereo state-variable filter with cubic soft-clip distortion and dry/wet mix.
// ----------------------------------------------------------------------------
// Usage:
//  - Input stream s_*: one stereo sample pair per item, Q1.23 each.
//  - Output stream m_*: one mixed, saturated pair per input item.
//  - Config cfg_*: writes one coefficient register by index (Q8.16, drive
//    Q7.16, gains Q1.16); always ready. Write only while the block is idle.
//  - Each channel has its own lane with one multiplier; both lanes run the
//    same 18-step multiply/writeback schedule from the controller. The
//    dependent chain through the filter and the two clipper cubes sets
//    that length.
//  - Items do not overlap: s_tready is high only in the idle state, so a
//    new item is taken only once the last one is in the output register.
//  - The output register holds a result while the next item is accepted and
//    processed; if the receiver still stalls when that one finishes, the
//    controller holds it and s_tready stays low until the register frees.
//  - Reset (synchronous, active high) clears the filter state, empties the
//    output register and loads the default coefficients.
// ----------------------------------------------------------------------------
module stereo_svf_soft_clip_distortion (
  input  logic                              clk,
  input  logic                              rst,
  // input stream
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [2*ssc_pkg::SAMPLE_BITS-1:0] s_tdata,   // left_in, right_in
  // output stream
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [2*ssc_pkg::SAMPLE_BITS-1:0] m_tdata,   // left_out, right_out
  // configuration writes
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [ssc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ssc_pkg::COEF_W-1:0]        cfg_data
);
  import ssc_pkg::*;

  coef_t    coef;
  ssc_cmd_t cmd;
  logic     out_free;

  logic signed [SAMPLE_BITS-1:0] left_in;
  logic signed [SAMPLE_BITS-1:0] right_in;
  logic signed [SAMPLE_BITS-1:0] left_mix;
  logic signed [SAMPLE_BITS-1:0] right_mix;

  assign left_in  = signed'(s_tdata[SAMPLE_BITS-1:0]);
  assign right_in = signed'(s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]);

  // coefficient registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef.feedback <= COEF_W'(46811);
      coef.tune     <= COEF_W'(17957);
      coef.update   <= -COEF_W'(25140);
      coef.highpass <= -COEF_W'(75918);
      coef.drive    <= DRIVE_W'(52429);
      coef.trim     <= GAIN_W'(65536);
      coef.dry      <= '0;
      coef.wet      <= GAIN_W'(65536);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_FEEDBACK: coef.feedback <= signed'(cfg_data);
        REG_TUNE:     coef.tune     <= signed'(cfg_data);
        REG_UPDATE:   coef.update   <= signed'(cfg_data);
        REG_HIGHPASS: coef.highpass <= signed'(cfg_data);
        REG_DRIVE:    coef.drive    <= cfg_data[DRIVE_W-1:0];
        REG_TRIM:     coef.trim     <= cfg_data[GAIN_W-1:0];
        REG_DRY:      coef.dry      <= cfg_data[GAIN_W-1:0];
        REG_WET:      coef.wet      <= cfg_data[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // output register is free when empty or being taken this cycle
  assign out_free = !m_tvalid || m_tready;

  ssc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .out_free (out_free),
    .cmd      (cmd)
  );

  ssc_lane u_left (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .coef       (coef),
    .sample_in  (left_in),
    .sample_out (left_mix)
  );

  ssc_lane u_right (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .coef       (coef),
    .sample_in  (right_in),
    .sample_out (right_mix)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      m_tdata <= {right_mix, left_mix};
    end
  end

endmodule

>>> dv/tb_stereo_svf_soft_clip_distortion.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_stereo_svf_soft_clip_distortion
// Self-checking bench for the stereo SVF soft-clip distortion block. A
// bit-true fixed-point filter/clipper model predicts every output pair from
// the accepted input pairs and the coefficient writes. Both stream sides
// idle at random. Coefficients are changed only while the block is empty.
// ----------------------------------------------------------------------------
module tb_stereo_svf_soft_clip_distortion;
  import ssc_pkg::*;

  localparam int SB = SAMPLE_BITS;
  localparam logic [SB-1:0] SMP_MAX = {1'b0, {(SB-1){1'b1}}};
  localparam logic [SB-1:0] SMP_MIN = {1'b1, {(SB-1){1'b0}}};

  // one raw word per coefficient register, as written on the config channel
  typedef struct {
    logic [COEF_W-1:0] feedback, tune, update, highpass, drive, trim, dry, wet;
  } coef_words_t;

  // --------------------------------------------------------------------------
  // Scoreboard: fixed-point model of both filter lanes plus the queue of
  // output pairs still owed by the block.
  // --------------------------------------------------------------------------
  class distortion_scoreboard;
    longint coef [NUM_REGS];
    longint band_st [2];
    longint low_st [2];
    logic [2*SB-1:0] expected_pairs [$];
    int mismatches;

    function new();
      coef[REG_FEEDBACK] = 46811;
      coef[REG_TUNE]     = 17957;
      coef[REG_UPDATE]   = -25140;
      coef[REG_HIGHPASS] = -75918;
      coef[REG_DRIVE]    = 52429;
      coef[REG_TRIM]     = 65536;
      coef[REG_DRY]      = 0;
      coef[REG_WET]      = 65536;
      band_st = '{0, 0};
      low_st  = '{0, 0};
      mismatches = 0;
    endfunction

    // signed regs are sign-extended from 24 bits, gains masked to their width
    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [COEF_W-1:0] val);
      unique case (idx) inside
        REG_FEEDBACK, REG_TUNE, REG_UPDATE, REG_HIGHPASS: begin
          coef[idx] = longint'($signed(val));
        end
        REG_DRIVE: begin
          coef[idx] = longint'(val[DRIVE_W-1:0]);
        end
        default: begin
          coef[idx] = longint'(val[GAIN_W-1:0]);
        end
      endcase
    endfunction

    // round to nearest, ties toward +inf
    function longint round_shift(longint v, int s);
      return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function longint saturate(longint v, int w);
      longint hi;
      longint lo;
      hi = (longint'(1) << (w - 1)) - 1;
      lo = -hi - 1;
      return (v > hi) ? hi : ((v < lo) ? lo : v);
    endfunction

    // drive gain, hard limit at +/-1.0, then 1.5x - 0.5x^3
    function longint soft_clip(longint y);
      longint one;
      longint x;
      longint x2;
      longint x3;
      one = longint'(1) << FRAC_BITS;
      x = round_shift(y * coef[REG_DRIVE], COEF_FRAC_BITS);
      if (x < -one) return -one;
      if (x > one) return one;
      x2 = round_shift(x * x, FRAC_BITS);
      x3 = round_shift(x2 * x, FRAC_BITS);
      return round_shift(3 * x - x3, 1);
    endfunction

    function longint filter_channel(int ch, longint smp);
      longint diff;
      longint acc;
      longint wet;
      longint mix;
      band_st[ch] = saturate(band_st[ch] +
                             round_shift(low_st[ch] * coef[REG_TUNE], COEF_FRAC_BITS),
                             STATE_BITS);
      diff = saturate(round_shift(band_st[ch] * coef[REG_FEEDBACK], COEF_FRAC_BITS) +
                      low_st[ch] - smp, STATE_BITS);
      low_st[ch] = saturate(low_st[ch] +
                            round_shift(diff * coef[REG_UPDATE], COEF_FRAC_BITS),
                            STATE_BITS);
      acc = round_shift(diff * coef[REG_HIGHPASS], COEF_FRAC_BITS) +
            soft_clip(band_st[ch]) + soft_clip(low_st[ch]);
      acc = saturate(acc, STATE_BITS);
      wet = round_shift(acc * coef[REG_TRIM], COEF_FRAC_BITS);
      mix = round_shift(smp * coef[REG_DRY] + wet * coef[REG_WET], COEF_FRAC_BITS);
      return saturate(mix, SB);
    endfunction

    function void note_input(logic [2*SB-1:0] data);
      longint lo;
      longint ro;
      lo = filter_channel(0, longint'($signed(data[SB-1:0])));
      ro = filter_channel(1, longint'($signed(data[2*SB-1:SB])));
      expected_pairs.push_back({ro[SB-1:0], lo[SB-1:0]});
    endfunction

    function int pending();
      return expected_pairs.size();
    endfunction

    task report_mismatch(string what);
      $display("[%0t] MISMATCH: %s", $realtime, what);
      mismatches++;
    endtask

    task check_output(logic [2*SB-1:0] data);
      logic [2*SB-1:0] exp_pair;
      if (expected_pairs.size() == 0) begin
        report_mismatch($sformatf("unexpected output item %h", data));
      end else begin
        exp_pair = expected_pairs.pop_front();
        if (data[SB-1:0] !== exp_pair[SB-1:0])
          report_mismatch($sformatf("left_out exp %0d got %0d",
                                    $signed(exp_pair[SB-1:0]), $signed(data[SB-1:0])));
        if (data[2*SB-1:SB] !== exp_pair[2*SB-1:SB])
          report_mismatch($sformatf("right_out exp %0d got %0d",
                                    $signed(exp_pair[2*SB-1:SB]),
                                    $signed(data[2*SB-1:SB])));
      end
    endtask
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset, DUT
  // --------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [2*SB-1:0]        s_tdata = '0;     // left_in, right_in
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [2*SB-1:0]        m_tdata;          // left_out, right_out
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = REG_FEEDBACK;
  logic [COEF_W-1:0]      cfg_data = '0;

  // per-item idle ceilings for each side; 0 gives back-to-back stretches
  int tx_gap_max = 0;
  int rx_gap_max = 0;

  distortion_scoreboard sb = new();

  always #5 clk = ~clk;

  stereo_svf_soft_clip_distortion dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------
  // Leaves cfg_valid high so back-to-back writes never toggle it in one step;
  // apply_coefs drops it after the last register.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COEF_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!(cfg_valid && cfg_ready)) @(posedge clk);
    sb.write_reg(idx, val);
  endtask

  task automatic apply_coefs(input coef_words_t c);
    write_reg(REG_FEEDBACK, c.feedback);
    write_reg(REG_TUNE,     c.tune);
    write_reg(REG_UPDATE,   c.update);
    write_reg(REG_HIGHPASS, c.highpass);
    write_reg(REG_DRIVE,    c.drive);
    write_reg(REG_TRIM,     c.trim);
    write_reg(REG_DRY,      c.dry);
    write_reg(REG_WET,      c.wet);
    cfg_valid <= 1'b0;
  endtask

  // The model is updated right at the accepting edge, so pending() seen by
  // this process always includes the item just sent.
  task automatic send_pair(input logic [SB-1:0] l, input logic [SB-1:0] r);
    int gap;
    gap = $urandom_range(0, tx_gap_max);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {r, l};
    @(posedge clk);
    while (!(s_tvalid && s_tready)) @(posedge clk);
    sb.note_input({r, l});
  endtask

  // Sender holds off until the block has handed back every pair.
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Audio-like magnitudes in half the draws, plus full-scale noise and rail values.
  function automatic logic [SB-1:0] pick_sample();
    logic signed [SB-1:0] v;
    v = SB'($urandom);
    case ($urandom_range(0, 9)) inside
      0, 1, 2, 3: return v;
      4, 5, 6:    return v >>> $urandom_range(1, 12);
      7, 8:       return SB'($urandom_range(0, 8191)) - SB'(4096);
      default:    return $urandom_range(0, 1) ? SMP_MAX : SMP_MIN;
    endcase
  endfunction

  // Coefficient sets: stable filters near the usual operating point, fully
  // random words (upper bits of the gain words exercise masking), or rails.
  function automatic coef_words_t pick_coefs();
    coef_words_t c;
    int tune;
    case ($urandom_range(0, 3)) inside
      0, 1: begin
        tune = $urandom_range(500, 60000);
        c.tune     = COEF_W'(tune);
        c.feedback = COEF_W'($urandom_range(20000, 131072));
        c.update   = COEF_W'(-(tune * 7 / 5));
        c.highpass = COEF_W'(-$urandom_range(0, 131072));
        c.drive    = COEF_W'($urandom_range(0, 262144));
        c.trim     = COEF_W'($urandom_range(0, 65536));
        c.dry      = COEF_W'($urandom_range(0, 65536));
        c.wet      = COEF_W'($urandom_range(0, 65536));
      end
      2: begin
        c.feedback = COEF_W'($urandom);
        c.tune     = COEF_W'($urandom);
        c.update   = COEF_W'($urandom);
        c.highpass = COEF_W'($urandom);
        c.drive    = COEF_W'($urandom);
        c.trim     = COEF_W'($urandom);
        c.dry      = COEF_W'($urandom);
        c.wet      = COEF_W'($urandom);
      end
      default: begin
        c.feedback = $urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000;
        c.tune     = $urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000;
        c.update   = $urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000;
        c.highpass = $urandom_range(0, 1) ? 24'h000000 : 24'h800000;
        c.drive    = $urandom_range(0, 1) ? 24'h7FFFFF : 24'h000000;
        c.trim     = $urandom_range(0, 1) ? 24'h01FFFF : 24'h010000;
        c.dry      = $urandom_range(0, 1) ? 24'h01FFFF : 24'h000000;
        c.wet      = $urandom_range(0, 1) ? 24'h01FFFF : 24'h010000;
      end
    endcase
    return c;
  endfunction

  // --------------------------------------------------------------------------
  // Receiver: random stall before each item, then ready until it is taken.
  // --------------------------------------------------------------------------
  initial begin
    int gap;
    wait (!rst);
    forever begin
      gap = $urandom_range(0, rx_gap_max);
      if (gap != 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!(m_tvalid && m_tready)) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_output(m_tdata);
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    coef_words_t c;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed, default coefficients: rails, sign flips, bit patterns.
    send_pair('0, '0);
    send_pair(SMP_MAX, SMP_MIN);
    send_pair(SMP_MIN, SMP_MAX);
    send_pair(SMP_MAX, SMP_MAX);
    send_pair(SMP_MIN, SMP_MIN);
    send_pair(SB'(1), '1);
    send_pair(24'hAAAAAA, 24'h555555);
    send_pair(24'h555555, 24'hAAAAAA);
    send_pair(SMP_MAX, SMP_MAX);
    send_pair(SMP_MAX, SMP_MAX);
    send_pair('0, '0);
    send_pair('1, SB'(1));
    wait_idle();

    // Rails on every register: integrator and difference saturation, clipper
    // hard limit, wet-sum and output saturation, gains above unity. Upper
    // bits of the unsigned words are set to check the width masking.
    c.feedback = 24'h7FFFFF;
    c.tune     = 24'h7FFFFF;
    c.update   = 24'h800000;
    c.highpass = 24'h7FFFFF;
    c.drive    = 24'hFFFFFF;
    c.trim     = 24'hFFFFFF;
    c.dry      = 24'hFFFFFF;
    c.wet      = 24'hFFFFFF;
    apply_coefs(c);
    tx_gap_max = 3;
    rx_gap_max = 3;
    send_pair(SMP_MAX, SMP_MIN);
    send_pair(SMP_MAX, SMP_MIN);
    send_pair(SMP_MIN, SMP_MAX);
    send_pair(SMP_MIN, SMP_MIN);
    send_pair(SMP_MAX, SMP_MAX);
    send_pair('0, '0);
    send_pair(SB'(1), '1);
    send_pair(SMP_MIN, SMP_MAX);
    wait_idle();

    // All-zero coefficients: output must be silent whatever the input.
    c.feedback = '0;
    c.tune     = '0;
    c.update   = '0;
    c.highpass = '0;
    c.drive    = '0;
    c.trim     = '0;
    c.dry      = '0;
    c.wet      = '0;
    apply_coefs(c);
    send_pair(SMP_MAX, SMP_MIN);
    send_pair(SMP_MIN, SMP_MAX);
    send_pair(24'h123456, 24'hFEDCBA);
    send_pair('0, '0);
    wait_idle();

    // Random phases, each with its own coefficients and idle profile.
    for (int ph = 0; ph < 12; ph++) begin
      apply_coefs(pick_coefs());
      case ($urandom_range(0, 3))
        0:       begin tx_gap_max = 0;  rx_gap_max = 0;  end
        1:       begin tx_gap_max = 18; rx_gap_max = 0;  end
        2:       begin tx_gap_max = 0;  rx_gap_max = 18; end
        default: begin tx_gap_max = 18; rx_gap_max = 18; end
      endcase
      for (int n = 0; n < 100; n++) begin
        // occasional short back-to-back bursts inside a phase
        if ($urandom_range(0, 19) == 0) tx_gap_max = (tx_gap_max == 0) ? 18 : 0;
        send_pair(pick_sample(), pick_sample());
      end
      wait_idle();
    end

    // drained; give the block a result-latency margin for stray items
    repeat (25) @(posedge clk);
    if (sb.pending() != 0) sb.report_mismatch("expected items never arrived");
    if (sb.mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // run limit, several times the slowest legal run
  initial begin
    #5ms;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
